FILE: rtl/ls3_pkg.sv
`default_nettype none

package ls3_pkg;

  // Field format.
  localparam int DW = 32;
  localparam int FB = 16;

  // Internal widths: pair products, adjugate entries, determinant, numerator,
  // divider compare word and the determinant after the output rescale.
  localparam int PW   = 2 * DW;
  localparam int AW   = 2 * DW + 1;
  localparam int DETW = 3 * DW + 2;
  localparam int NUMW = DETW + FB;
  localparam int DVW  = DETW + DW + 1;
  localparam int DQW  = DETW - 2 * FB;

  // Pipeline stage numbers.
  localparam int ST_PROD = 0;
  localparam int ST_ADJ  = 1;
  localparam int ST_PART = 2;
  localparam int ST_TERM = 3;
  localparam int ST_SUM  = 4;
  localparam int ST_ABS  = 5;
  localparam int ST_CHK  = 6;
  localparam int ST_DIV0 = 7;
  localparam int ST_SAT  = ST_DIV0 + DW;
  localparam int ST_OUT  = ST_SAT + 1;
  localparam int NSTG    = ST_OUT + 1;

  // Saturation bounds.
  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic signed [DW-1:0] m00;
    logic signed [DW-1:0] m01;
    logic signed [DW-1:0] m02;
    logic signed [DW-1:0] m10;
    logic signed [DW-1:0] m11;
    logic signed [DW-1:0] m12;
    logic signed [DW-1:0] m20;
    logic signed [DW-1:0] m21;
    logic signed [DW-1:0] m22;
    logic signed [DW-1:0] rhs0;
    logic signed [DW-1:0] rhs1;
    logic signed [DW-1:0] rhs2;
  } ls3_in_t;

  typedef struct packed {
    logic signed [DW-1:0] sol0;
    logic signed [DW-1:0] sol1;
    logic signed [DW-1:0] sol2;
    logic signed [DW-1:0] determinant;
    logic                 singular;
    logic                 overflow;
  } ls3_out_t;

  typedef logic [2:0][AW-1:0] ls3_row_t;
  typedef ls3_row_t [2:0]     ls3_adj_t;
  typedef logic [2:0][DW-1:0] ls3_vec_t;

  typedef struct packed {
    logic [DW-1:0] sol;
    logic          ovf;
  } ls3_lane_t;

  typedef struct packed {
    logic [DW-1:0] det;
    logic          ovf;
    logic          sing;
  } ls3_dinfo_t;

  // Low partial product: x times the unsigned low word of a wide operand.
  function automatic logic signed [AW-1:0] ls3_mul_lo(input logic signed [DW-1:0] x,
                                                      input logic [AW-1:0] y);
    logic signed [DW:0] yl;
    yl = $signed({1'b0, y[DW-1:0]});
    return x * yl;
  endfunction

  // High partial product: x times the signed upper part of a wide operand.
  function automatic logic signed [AW-1:0] ls3_mul_hi(input logic signed [DW-1:0] x,
                                                      input logic [AW-1:0] y);
    logic signed [AW-DW-1:0] yh;
    yh = $signed(y[AW-1:DW]);
    return x * yh;
  endfunction

  // Recombine the two partial products into the full product.
  function automatic logic signed [DETW-1:0] ls3_join(input logic signed [AW-1:0] ph,
                                                      input logic signed [AW-1:0] pl);
    return (DETW'(ph) <<< DW) + DETW'(pl);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/linear_solve_3x3.sv
// Cramer's-rule solver for one 3x3 system in signed Q16.16 per transfer.
// Input channel: in_valid/in_ready with in_data holding the matrix m00..m22
// and the right-hand vector rhs0..rhs2. Result channel: out_valid/out_ready
// with out_data holding sol0..sol2, the determinant, a singular flag (exact
// determinant zero, solutions then zero) and an overflow flag (some field
// was clamped to the 32-bit range).
// A new system is taken every cycle unless the pipeline is full and the
// receiver stalls: the products, the adjugate and the determinant are
// pipelined, and each of the three solution lanes has a 32-stage
// restoring divider with one quotient bit per stage.
// Every stage carries a valid bit. A stage moves forward when it is empty or
// the stage after it moves, so in_ready stays high while bubbles remain,
// even when a finished result waits at the output register.
// When the receiver stalls, out_data holds until the transfer completes and
// the pipeline fills up behind it; in_ready drops once all stages are full.
// Reset clears all valid bits; nothing else needs clearing.
`default_nettype none

module linear_solve_3x3 (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ls3_pkg::ls3_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ls3_pkg::ls3_out_t     out_data
);
  import ls3_pkg::*;

  logic [NSTG-1:0]        vld_r, vld_nxt, en;
  ls3_adj_t               adj;
  ls3_vec_t               vec;
  logic signed [DETW-1:0] det;
  ls3_lane_t [2:0]        lane_res;

  // Stage enables: a stage advances if any stage from it to the output is
  // empty, or the output transfer happens.
  for (genvar s = 0; s < NSTG; s++) begin : g_en
    assign en[s] = out_ready | ~(&vld_r[NSTG-1:s]);
  end

  assign vld_nxt = (en & {vld_r[NSTG-2:0], in_valid}) | (~en & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[ST_OUT];

  ls3_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .adj_o   (adj),
    .vec_o   (vec),
    .det_o   (det)
  );

  // One lane per solution component.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    ls3_lane u_lane (
      .clk     (clk),
      .en      (en),
      .adj_row (adj[i]),
      .vec_i   (vec),
      .det_i   (det),
      .res_o   (lane_res[i])
    );
  end

  ls3_merge u_merge (
    .clk    (clk),
    .en     (en),
    .det_i  (det),
    .lane_i (lane_res),
    .out_o  (out_data)
  );

`ifndef SYNTH
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[ST_OUT] |-> in_ready)
    else $error("input stalled with an empty output stage");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(out_valid && out_ready))
    |=> $countones(vld_r) == $past($countones(vld_r)) + 1)
    else $error("accepted transfer lost in the pipeline");

  a_singular_zero_sol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular)
    |-> (out_data.sol0 == '0 && out_data.sol1 == '0 && out_data.sol2 == '0))
    else $error("singular result with nonzero solution");

  a_singular_det: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular)
    |-> (out_data.determinant == '0 && !out_data.overflow))
    else $error("singular result with nonzero determinant or overflow");
`endif

endmodule

`default_nettype wire

FILE: rtl/ls3_front.sv
`default_nettype none

module ls3_front (
  input  wire logic                     clk,
  input  wire logic [ls3_pkg::NSTG-1:0] en,
  input  wire ls3_pkg::ls3_in_t         in_data,
  output ls3_pkg::ls3_adj_t             adj_o,
  output ls3_pkg::ls3_vec_t             vec_o,
  output logic signed [ls3_pkg::DETW-1:0] det_o
);
  import ls3_pkg::*;

  logic signed [PW-1:0] ek_r, fh_r, ch_r, bk_r, bf_r, ce_r, fg_r, dk_r, ak_r;
  logic signed [PW-1:0] cg_r, cd_r, af_r, dh_r, eg_r, bg_r, ah_r, ae_r, bd_r;
  logic [2:0][DW-1:0]   row0_r, row1_r;
  ls3_vec_t             vec0_r, vec1_r;
  ls3_adj_t             adj_r;
  logic signed [AW-1:0] pl_r [3];
  logic signed [AW-1:0] ph_r [3];
  logic signed [DETW-1:0] term_r [3];
  logic signed [DETW-1:0] det_r;

  // All pairwise products that the cofactors need.
  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      ek_r   <= in_data.m11 * in_data.m22;
      fh_r   <= in_data.m12 * in_data.m21;
      ch_r   <= in_data.m02 * in_data.m21;
      bk_r   <= in_data.m01 * in_data.m22;
      bf_r   <= in_data.m01 * in_data.m12;
      ce_r   <= in_data.m02 * in_data.m11;
      fg_r   <= in_data.m12 * in_data.m20;
      dk_r   <= in_data.m10 * in_data.m22;
      ak_r   <= in_data.m00 * in_data.m22;
      cg_r   <= in_data.m02 * in_data.m20;
      cd_r   <= in_data.m02 * in_data.m10;
      af_r   <= in_data.m00 * in_data.m12;
      dh_r   <= in_data.m10 * in_data.m21;
      eg_r   <= in_data.m11 * in_data.m20;
      bg_r   <= in_data.m01 * in_data.m20;
      ah_r   <= in_data.m00 * in_data.m21;
      ae_r   <= in_data.m00 * in_data.m11;
      bd_r   <= in_data.m01 * in_data.m10;
      row0_r <= {in_data.m02, in_data.m01, in_data.m00};
      vec0_r <= {in_data.rhs2, in_data.rhs1, in_data.rhs0};
    end
  end

  // Adjugate: transposed cofactors.
  always_ff @(posedge clk) begin
    if (en[ST_ADJ]) begin
      adj_r[0][0] <= AW'(ek_r) - AW'(fh_r);
      adj_r[0][1] <= AW'(ch_r) - AW'(bk_r);
      adj_r[0][2] <= AW'(bf_r) - AW'(ce_r);
      adj_r[1][0] <= AW'(fg_r) - AW'(dk_r);
      adj_r[1][1] <= AW'(ak_r) - AW'(cg_r);
      adj_r[1][2] <= AW'(cd_r) - AW'(af_r);
      adj_r[2][0] <= AW'(dh_r) - AW'(eg_r);
      adj_r[2][1] <= AW'(bg_r) - AW'(ah_r);
      adj_r[2][2] <= AW'(ae_r) - AW'(bd_r);
      row1_r      <= row0_r;
      vec1_r      <= vec0_r;
    end
  end

  // Determinant by expansion along row 0, split into partial products.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (en[ST_PART]) begin
        pl_r[j] <= ls3_mul_lo($signed(row1_r[j]), adj_r[j][0]);
        ph_r[j] <= ls3_mul_hi($signed(row1_r[j]), adj_r[j][0]);
      end
      if (en[ST_TERM]) begin
        term_r[j] <= ls3_join(ph_r[j], pl_r[j]);
      end
    end
    if (en[ST_SUM]) begin
      det_r <= term_r[0] + term_r[1] + term_r[2];
    end
  end

  assign adj_o = adj_r;
  assign vec_o = vec1_r;
  assign det_o = det_r;

endmodule

`default_nettype wire

FILE: rtl/ls3_lane.sv
`default_nettype none

module ls3_lane (
  input  wire logic                       clk,
  input  wire logic [ls3_pkg::NSTG-1:0]   en,
  input  wire ls3_pkg::ls3_row_t          adj_row,
  input  wire ls3_pkg::ls3_vec_t          vec_i,
  input  wire logic signed [ls3_pkg::DETW-1:0] det_i,
  output ls3_pkg::ls3_lane_t              res_o
);
  import ls3_pkg::*;

  logic signed [AW-1:0]   pl_r [3];
  logic signed [AW-1:0]   ph_r [3];
  logic signed [DETW-1:0] term_r [3];
  logic signed [NUMW-1:0] num_r;
  logic [NUMW-1:0]        an_r;
  logic [DETW-1:0]        ad0_r;
  logic                   neg0_r, sing0_r;
  logic [DVW-1:0]         chk;

  logic [NUMW-1:0] rem_r  [DW];
  logic [DETW-1:0] ad_r   [DW];
  logic [DW-1:0]   q_r    [DW+1];
  logic            neg_r  [DW+1];
  logic            sing_r [DW+1];
  logic            big_r  [DW+1];

  ls3_lane_t res_r, res_nxt;

  // Numerator: one row of the adjugate times the right-hand vector.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (en[ST_PART]) begin
        pl_r[j] <= ls3_mul_lo($signed(vec_i[j]), adj_row[j]);
        ph_r[j] <= ls3_mul_hi($signed(vec_i[j]), adj_row[j]);
      end
      if (en[ST_TERM]) begin
        term_r[j] <= ls3_join(ph_r[j], pl_r[j]);
      end
    end
    if (en[ST_SUM]) begin
      num_r <= NUMW'(term_r[0] + term_r[1] + term_r[2]) <<< FB;
    end
  end

  // Magnitudes and quotient sign.
  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      an_r    <= num_r[NUMW-1] ? NUMW'(-num_r) : num_r;
      ad0_r   <= det_i[DETW-1] ? DETW'(-det_i) : det_i;
      neg0_r  <= num_r[NUMW-1] ^ det_i[DETW-1];
      sing0_r <= (det_i == '0);
    end
  end

  // A quotient of 2^DW or more saturates no matter what the low bits are.
  assign chk = DVW'(an_r) - (DVW'(ad0_r) << DW);

  always_ff @(posedge clk) begin
    if (en[ST_CHK]) begin
      rem_r[0]  <= an_r;
      ad_r[0]   <= ad0_r;
      q_r[0]    <= '0;
      neg_r[0]  <= neg0_r;
      sing_r[0] <= sing0_r;
      big_r[0]  <= ~chk[DVW-1];
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DW; k++) begin : g_div
    localparam int BIT = DW - 1 - k;
    logic [DVW-1:0] diff;
    logic           take;

    assign diff = DVW'(rem_r[k]) - (DVW'(ad_r[k]) << BIT);
    assign take = ~diff[DVW-1];

    always_ff @(posedge clk) begin
      if (en[ST_DIV0 + k]) begin
        q_r[k+1]    <= q_r[k] | (DW'(take) << BIT);
        neg_r[k+1]  <= neg_r[k];
        sing_r[k+1] <= sing_r[k];
        big_r[k+1]  <= big_r[k];
      end
    end

    if (k < DW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[ST_DIV0 + k]) begin
          rem_r[k+1] <= take ? diff[NUMW-1:0] : rem_r[k];
          ad_r[k+1]  <= ad_r[k];
        end
      end
    end
  end

  // Apply the sign and clamp to the output range.
  always_comb begin
    res_nxt.sol = q_r[DW];
    res_nxt.ovf = 1'b0;
    if (sing_r[DW]) begin
      res_nxt.sol = '0;
    end else if (big_r[DW]) begin
      res_nxt.sol = neg_r[DW] ? SMIN : SMAX;
      res_nxt.ovf = 1'b1;
    end else if (!neg_r[DW]) begin
      if (q_r[DW][DW-1]) begin
        res_nxt.sol = SMAX;
        res_nxt.ovf = 1'b1;
      end
    end else if (q_r[DW][DW-1] && (|q_r[DW][DW-2:0])) begin
      res_nxt.sol = SMIN;
      res_nxt.ovf = 1'b1;
    end else begin
      res_nxt.sol = DW'(-q_r[DW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SAT]) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

`default_nettype wire

FILE: rtl/ls3_merge.sv
`default_nettype none

module ls3_merge (
  input  wire logic                       clk,
  input  wire logic [ls3_pkg::NSTG-1:0]   en,
  input  wire logic signed [ls3_pkg::DETW-1:0] det_i,
  input  wire ls3_pkg::ls3_lane_t [2:0]   lane_i,
  output ls3_pkg::ls3_out_t               out_o
);
  import ls3_pkg::*;

  logic signed [DETW-1:0] ds;
  logic [DQW-1:0]         dq;
  logic                   fits;
  ls3_dinfo_t             info_nxt;
  ls3_dinfo_t             dly_r [ST_ABS:ST_SAT];
  ls3_out_t               out_r, out_nxt;

  // Rescale the determinant to the output format, rounding toward zero.
  always_comb begin
    ds   = det_i + (det_i[DETW-1] ? DETW'({(2*FB){1'b1}}) : DETW'(0));
    dq   = ds[DETW-1:2*FB];
    fits = (&dq[DQW-1:DW-1]) | ~(|dq[DQW-1:DW-1]);
    info_nxt.det  = fits ? dq[DW-1:0] : (dq[DQW-1] ? SMIN : SMAX);
    info_nxt.ovf  = ~fits;
    info_nxt.sing = (det_i == '0);
  end

  // Delay line that keeps the determinant fields beside the lanes.
  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      dly_r[ST_ABS] <= info_nxt;
    end
    for (int s = ST_ABS + 1; s <= ST_SAT; s++) begin
      if (en[s]) begin
        dly_r[s] <= dly_r[s-1];
      end
    end
  end

  // Merge the lane results with the determinant fields.
  always_comb begin
    out_nxt.sol0        = lane_i[0].sol;
    out_nxt.sol1        = lane_i[1].sol;
    out_nxt.sol2        = lane_i[2].sol;
    out_nxt.determinant = dly_r[ST_SAT].det;
    out_nxt.singular    = dly_r[ST_SAT].sing;
    out_nxt.overflow    = dly_r[ST_SAT].ovf | lane_i[0].ovf | lane_i[1].ovf
                          | lane_i[2].ovf;
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_o = out_r;

endmodule

`default_nettype wire
